// File: design/slb_pkg.sv
`default_nettype none

package slb_pkg;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_REFRESH = 1'b1;

    localparam logic [1:0] MODE_STD   = 2'd0;
    localparam logic [1:0] MODE_ECO   = 2'd1;
    localparam logic [1:0] MODE_MAINT = 2'd2;

    localparam logic [2:0] COL_RED    = 3'd0;
    localparam logic [2:0] COL_GREEN  = 3'd1;
    localparam logic [2:0] COL_YELLOW = 3'd2;
    localparam logic [2:0] COL_BLUE   = 3'd3;
    localparam logic [2:0] COL_WHITE  = 3'd4;
    localparam logic [2:0] COL_ORANGE = 3'd5;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_MAX     = 3'd6;
    localparam logic [3:0] SHOWN_ERR_OFFSET = 4'd2;
    localparam logic [3:0] SHOWN_MAX   = 4'd8;

    // Blink phases at which red and then the error color are written.
    localparam logic [2:0] PH_SHORT_RED = 3'd2;
    localparam logic [2:0] PH_SHORT_COL = 3'd4;
    localparam logic [2:0] PH_LONG_RED  = 3'd4;
    localparam logic [2:0] PH_LONG_COL  = 3'd6;

    localparam logic [15:0] PRESS_TICKS_RESET = 16'd10;

    typedef struct packed {
        logic       opcode;
        logic       red_pressed;
        logic       green_pressed;
        logic [2:0] error_code;
    } in_item_t;

    typedef struct packed {
        logic       color_write;
        logic [2:0] color;
        logic [1:0] active_mode;
        logic [3:0] shown_mode;
    } result_t;

    typedef struct packed {
        logic [3:0] shown_mode;
        logic [1:0] active_mode;
        logic [1:0] previous_mode;
        logic [2:0] blink_phase;
    } led_state_t;

    // Error color by shown mode (error code plus two).
    function automatic logic [2:0] err_color(input logic [3:0] shown);
        logic [2:0] col;
        case (shown)
            4'd3:    col = COL_GREEN;
            4'd4:    col = COL_YELLOW;
            4'd5:    col = COL_BLUE;
            4'd6:    col = COL_WHITE;
            4'd7:    col = COL_WHITE;
            4'd8:    col = COL_GREEN;
            default: col = COL_RED;
        endcase
        return col;
    endfunction

endpackage

`default_nettype wire

// File: design/status_led_blink_and_mode_switch_core.sv
`default_nettype none

// Channel  | Handshake               | Payload
// cfg      | cfg_valid / cfg_ready   | cfg_data = press_ticks
// s_axis   | s_axis_tvalid / tready  | tuser = opcode; tdata = buttons, error code
// m_axis   | m_axis_tvalid / tready  | tuser = color_write; tdata = color, modes
//
// One beat in gives one beat out: it passes the input register, then the
// next-state logic into the result register. A new beat is taken every cycle
// while the result register drains; a stalled m_axis holds both stages.
// Reset clears the modes, the blink phase and the hold counters, and loads
// press_ticks with 10. cfg_ready is always high.
module status_led_blink_and_mode_switch_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,      // press_ticks
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // red_pressed, green_pressed, error_code[2:0]
    input  wire logic [0:0]  s_axis_tuser,  // opcode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // color[2:0], active_mode[1:0], shown_mode[3:0]
    output logic [0:0]       m_axis_tuser   // color_write
);
    import slb_pkg::*;

    in_item_t               s_item;
    in_item_t               item;
    logic                   item_valid;
    logic                   advance;

    logic [15:0]            press_ticks_reg;
    led_state_t             state_reg;
    led_state_t             state_next;
    logic [COUNT_WIDTH-1:0] red_cnt_reg;
    logic [COUNT_WIDTH-1:0] red_cnt_next;
    logic [COUNT_WIDTH-1:0] green_cnt_reg;
    logic [COUNT_WIDTH-1:0] green_cnt_next;
    result_t                result_next;
    result_t                result_reg;
    logic                   out_valid_reg;

    assign s_item.opcode        = s_axis_tuser[0];
    assign s_item.red_pressed   = s_axis_tdata[0];
    assign s_item.green_pressed = s_axis_tdata[1];
    assign s_item.error_code    = s_axis_tdata[4:2];

    assign advance   = item_valid && (!out_valid_reg || m_axis_tready);
    assign cfg_ready = 1'b1;

    slb_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    slb_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .item           (item),
        .press_ticks    (press_ticks_reg),
        .cur            (state_reg),
        .red_cnt        (red_cnt_reg),
        .green_cnt      (green_cnt_reg),
        .nxt            (state_next),
        .red_cnt_next   (red_cnt_next),
        .green_cnt_next (green_cnt_next),
        .result         (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_ticks_reg <= PRESS_TICKS_RESET;
            state_reg       <= '0;
            red_cnt_reg     <= '0;
            green_cnt_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                press_ticks_reg <= cfg_data;
            end
            if (advance)
            begin
                state_reg     <= state_next;
                red_cnt_reg   <= red_cnt_next;
                green_cnt_reg <= green_cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = result_reg.color_write;
    assign m_axis_tdata  = {7'd0, result_reg.shown_mode, result_reg.active_mode,
                            result_reg.color};

    a_active_legal: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.active_mode != 2'd3)
        else $error("active mode holds an unused code");

    a_shown_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.shown_mode <= SHOWN_MAX)
        else $error("shown mode out of range");

    a_prev_differs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.active_mode == state_reg.previous_mode) |->
            (state_reg.active_mode == MODE_STD))
        else $error("previous mode equals a non-standard active mode");

    a_color_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[2:0] == COL_RED))
        else $error("color nonzero on a beat that writes no color");

    a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        $past(advance) |-> (result_reg.shown_mode == state_reg.shown_mode &&
                            result_reg.active_mode == state_reg.active_mode))
        else $error("result modes disagree with the state after the step");

endmodule

`default_nettype wire

// File: design/slb_in_reg.sv
`default_nettype none

module slb_in_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire slb_pkg::in_item_t s_item,
    input  wire logic             advance,
    output logic                  item_valid,
    output slb_pkg::in_item_t     item
);
    import slb_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // The stage refills in the same cycle it is drained.
    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// File: design/slb_step.sv
`default_nettype none

module slb_step #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire slb_pkg::in_item_t   item,
    input  wire logic [15:0]          press_ticks,
    input  wire slb_pkg::led_state_t cur,
    input  wire logic [COUNT_WIDTH-1:0] red_cnt,
    input  wire logic [COUNT_WIDTH-1:0] green_cnt,
    output slb_pkg::led_state_t      nxt,
    output logic [COUNT_WIDTH-1:0]   red_cnt_next,
    output logic [COUNT_WIDTH-1:0]   green_cnt_next,
    output slb_pkg::result_t         result
);
    import slb_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    logic [COUNT_WIDTH-1:0] red_inc;
    logic [COUNT_WIDTH-1:0] green_inc;
    logic                   red_long;
    logic                   green_long;
    logic [2:0]             err;
    logic                   wr;
    logic [2:0]             col;

    // Hold counters saturate at all ones.
    assign red_inc   = (&red_cnt)   ? red_cnt   : red_cnt + 1'b1;
    assign green_inc = (&green_cnt) ? green_cnt : green_cnt + 1'b1;
    assign red_long   = CMP_W'(red_inc)   > CMP_W'(press_ticks);
    assign green_long = CMP_W'(green_inc) > CMP_W'(press_ticks);
    assign err = (item.error_code > ERR_MAX) ? ERR_NONE : item.error_code;

    always_comb
    begin
        nxt            = cur;
        red_cnt_next   = red_cnt;
        green_cnt_next = green_cnt;
        wr             = 1'b0;
        col            = COL_RED;
        if (item.opcode == OP_TICK)
        begin
            case (cur.shown_mode) inside
                [4'd3:4'd6]:
                begin
                    if (cur.blink_phase == PH_SHORT_RED)
                    begin
                        wr = 1'b1;
                        col = COL_RED;
                        nxt.blink_phase = cur.blink_phase + 3'd1;
                    end
                    else if (cur.blink_phase == PH_SHORT_COL)
                    begin
                        wr = 1'b1;
                        col = err_color(cur.shown_mode);
                        nxt.blink_phase = 3'd0;
                    end
                    else
                    begin
                        nxt.blink_phase = cur.blink_phase + 3'd1;
                    end
                end
                [4'd7:4'd8]:
                begin
                    if (cur.blink_phase == PH_LONG_RED)
                    begin
                        wr = 1'b1;
                        col = COL_RED;
                        nxt.blink_phase = cur.blink_phase + 3'd1;
                    end
                    else if (cur.blink_phase == PH_LONG_COL)
                    begin
                        wr = 1'b1;
                        col = err_color(cur.shown_mode);
                        nxt.blink_phase = 3'd0;
                    end
                    else
                    begin
                        nxt.blink_phase = cur.blink_phase + 3'd1;
                    end
                end
                [4'd0:4'd2]:
                begin
                    wr = 1'b1;
                    nxt.blink_phase = 3'd0;
                    if (cur.shown_mode[1:0] == MODE_MAINT)
                    begin
                        col = COL_ORANGE;
                    end
                    else if (cur.shown_mode[1:0] == MODE_ECO)
                    begin
                        col = COL_BLUE;
                    end
                    else
                    begin
                        col = COL_GREEN;
                    end
                end
                default:
                begin
                    wr = 1'b0;
                end
            endcase

            if (item.red_pressed)
            begin
                red_cnt_next = red_inc;
                if (red_long)
                begin
                    red_cnt_next = '0;
                    if (cur.active_mode != MODE_MAINT)
                    begin
                        nxt.previous_mode = cur.active_mode;
                        nxt.active_mode   = MODE_MAINT;
                        nxt.shown_mode    = {2'b00, MODE_MAINT};
                    end
                    else
                    begin
                        nxt.active_mode   = cur.previous_mode;
                        nxt.previous_mode = MODE_MAINT;
                        nxt.shown_mode    = {2'b00, cur.previous_mode};
                    end
                end
            end
            else if (item.green_pressed)
            begin
                green_cnt_next = green_inc;
                if (green_long)
                begin
                    green_cnt_next = '0;
                    if (cur.active_mode == MODE_STD || cur.active_mode == MODE_ECO)
                    begin
                        nxt.previous_mode = cur.active_mode;
                        nxt.active_mode   = (cur.active_mode == MODE_STD) ? MODE_ECO : MODE_STD;
                        nxt.shown_mode    = (cur.active_mode == MODE_STD) ?
                                            {2'b00, MODE_ECO} : {2'b00, MODE_STD};
                    end
                end
            end
            else
            begin
                red_cnt_next   = '0;
                green_cnt_next = '0;
            end
        end
        else
        begin
            if (!(item.red_pressed && item.green_pressed) && err != ERR_NONE)
            begin
                nxt.shown_mode = {1'b0, err} + SHOWN_ERR_OFFSET;
            end
            else
            begin
                nxt.shown_mode = {2'b00, cur.active_mode};
            end
        end
    end

    assign result.color_write = wr;
    assign result.color       = wr ? col : COL_RED;
    assign result.active_mode = nxt.active_mode;
    assign result.shown_mode  = nxt.shown_mode;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import slb_pkg::*;

    localparam logic [2:0] ERR_SENSOR     = 3'd1;
    localparam logic [2:0] ERR_GPS        = 3'd2;
    localparam logic [2:0] ERR_CLOCK      = 3'd3;
    localparam logic [2:0] ERR_CARD_FULL  = 3'd4;
    localparam logic [2:0] ERR_CARD_WRITE = 3'd5;
    localparam logic [2:0] ERR_INCOHERENT = 3'd6;
    localparam logic [2:0] ERR_SEVEN      = 3'd7;

    localparam logic [3:0] SHOWN_STD        = 4'd0;
    localparam logic [3:0] SHOWN_SENSOR     = 4'd3;
    localparam logic [3:0] SHOWN_INCOHERENT = 4'd8;

    localparam logic [15:0] HOLD_TOP        = 16'hFFFF;
    localparam int          HOLD_RUN        = 24;
    localparam int          PRESSURE_CYCLES = 400;

    typedef struct packed {
        bit          is_cfg;
        logic [15:0] cfg_val;
        in_item_t    item;
        bit          typed;
        result_t     want;
    } plan_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    // Predicted state of the LED controller.
    logic [15:0] hold_limit       = PRESS_TICKS_RESET;
    logic [3:0]  led_shown        = SHOWN_STD;
    logic [1:0]  led_active       = MODE_STD;
    logic [1:0]  led_prev         = MODE_STD;
    logic [2:0]  blink_ph         = 3'd0;
    logic [15:0] red_held_ticks   = 16'd0;
    logic [15:0] green_held_ticks = 16'd0;

    result_t   led_expect_q[$];
    plan_row_t plan_q[$];

    int mismatch_count = 0;
    int beats_sent     = 0;
    int results_seen   = 0;
    int cfg_writes     = 0;
    bit steady_rate    = 1'b0;

    status_led_blink_and_mode_switch_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("tb_top: errors");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 88)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 30);
    endfunction

    // Advances the predicted state by one beat and returns the result it gives.
    function automatic result_t next_led_result(input in_item_t it);
        result_t    res;
        logic [2:0] err;
        logic [3:0] shown_off;
        logic [2:0] shown_err;
        logic [2:0] red_at;
        logic [2:0] hue_at;
        logic       blinking;
        res       = '0;
        blinking  = 1'b0;
        red_at    = PH_SHORT_RED;
        hue_at    = PH_SHORT_COL;
        shown_off = led_shown - SHOWN_ERR_OFFSET;
        shown_err = shown_off[2:0];
        err       = (it.error_code > ERR_MAX) ? ERR_NONE : it.error_code;
        if (it.opcode == OP_TICK)
        begin
            if (led_shown > {2'b00, MODE_MAINT} && led_shown <= SHOWN_MAX)
            begin
                blinking = 1'b1;
                if (shown_err >= ERR_CARD_WRITE)
                begin
                    red_at = PH_LONG_RED;
                    hue_at = PH_LONG_COL;
                end
            end
            if (blinking)
            begin
                // The phase wraps through all eight values, so a speed change
                // finds its matching points again after a while.
                if (blink_ph == red_at)
                begin
                    res.color_write = 1'b1;
                    res.color       = COL_RED;
                    blink_ph        = blink_ph + 3'd1;
                end
                else if (blink_ph == hue_at)
                begin
                    res.color_write = 1'b1;
                    case (shown_err)
                        ERR_SENSOR, ERR_INCOHERENT: res.color = COL_GREEN;
                        ERR_GPS:                    res.color = COL_YELLOW;
                        ERR_CLOCK:                  res.color = COL_BLUE;
                        default:                    res.color = COL_WHITE;
                    endcase
                    blink_ph = 3'd0;
                end
                else
                begin
                    blink_ph = blink_ph + 3'd1;
                end
            end
            else if (led_shown <= {2'b00, MODE_MAINT})
            begin
                blink_ph        = 3'd0;
                res.color_write = 1'b1;
                case (led_shown[1:0])
                    MODE_MAINT: res.color = COL_ORANGE;
                    MODE_ECO:   res.color = COL_BLUE;
                    default:    res.color = COL_GREEN;
                endcase
            end

            if (it.red_pressed)
            begin
                if (red_held_ticks != HOLD_TOP)
                    red_held_ticks = red_held_ticks + 16'd1;
                if (red_held_ticks > hold_limit)
                begin
                    red_held_ticks = 16'd0;
                    if (led_active != MODE_MAINT)
                    begin
                        led_prev   = led_active;
                        led_active = MODE_MAINT;
                    end
                    else
                    begin
                        led_active = led_prev;
                        led_prev   = MODE_MAINT;
                    end
                    led_shown = {2'b00, led_active};
                end
            end
            else if (it.green_pressed)
            begin
                if (green_held_ticks != HOLD_TOP)
                    green_held_ticks = green_held_ticks + 16'd1;
                if (green_held_ticks > hold_limit)
                begin
                    green_held_ticks = 16'd0;
                    if (led_active == MODE_STD || led_active == MODE_ECO)
                    begin
                        led_prev   = led_active;
                        led_active = (led_active == MODE_STD) ? MODE_ECO : MODE_STD;
                        led_shown  = {2'b00, led_active};
                    end
                end
            end
            else
            begin
                red_held_ticks   = 16'd0;
                green_held_ticks = 16'd0;
            end
        end
        else
        begin
            if (!(it.red_pressed && it.green_pressed) && err != ERR_NONE)
                led_shown = {1'b0, err} + SHOWN_ERR_OFFSET;
            else
                led_shown = {2'b00, led_active};
        end
        res.active_mode = led_active;
        res.shown_mode  = led_shown;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("tb_top: mismatch at result %0d: %s is %0d, expected %0d",
                 results_seen, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_beat(input in_item_t it, input bit typed, input result_t typed_res);
        int      gap;
        result_t predicted;
        gap = steady_rate ? 0 : gap_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, it.error_code, it.green_pressed, it.red_pressed};
        s_axis_tuser  <= it.opcode;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = next_led_result(it);
        led_expect_q.push_back(typed ? typed_res : predicted);
        beats_sent++;
    endtask

    // The register is only written once the block has drained.
    task automatic write_press_ticks(input logic [15:0] value);
        s_axis_tvalid <= 1'b0;
        while (led_expect_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        hold_limit = value;
        cfg_writes++;
    endtask

    task automatic add_row(input logic op, input logic red, input logic green,
                           input logic [2:0] err, input bit typed, input logic wr,
                           input logic [2:0] col, input logic [1:0] act,
                           input logic [3:0] shown);
        plan_row_t row;
        row                    = '0;
        row.item.opcode        = op;
        row.item.red_pressed   = red;
        row.item.green_pressed = green;
        row.item.error_code    = err;
        row.typed              = typed;
        row.want.color_write   = wr;
        row.want.color         = col;
        row.want.active_mode   = act;
        row.want.shown_mode    = shown;
        plan_q.push_back(row);
    endtask

    task automatic add_cfg(input logic [15:0] value);
        plan_row_t row;
        row         = '0;
        row.is_cfg  = 1'b1;
        row.cfg_val = value;
        plan_q.push_back(row);
    endtask

    // Buttons are held in runs, so presses get long enough to switch modes;
    // a few beats flip a button for one beat as a broken press.
    task automatic run_random(input int count);
        in_item_t it;
        bit       red_on;
        bit       green_on;
        int       k;
        red_on   = 1'b0;
        green_on = 1'b0;
        for (k = 0; k < count; k++)
        begin
            if (k % 64 == 0)
                steady_rate = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 11) == 0)
            begin
                case ($urandom_range(0, 4))
                    0: begin red_on = 1'b1; green_on = 1'b0; end
                    1: begin red_on = 1'b0; green_on = 1'b1; end
                    2: begin red_on = 1'b1; green_on = 1'b1; end
                    default: begin red_on = 1'b0; green_on = 1'b0; end
                endcase
            end
            it.opcode        = ($urandom_range(0, 99) < 15) ? OP_REFRESH : OP_TICK;
            it.red_pressed   = red_on;
            it.green_pressed = green_on;
            it.error_code    = 3'($urandom_range(0, 7));
            if ($urandom_range(0, 19) == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    it.red_pressed = !red_on;
                else
                    it.green_pressed = !green_on;
            end
            send_beat(it, 1'b0, '0);
        end
        steady_rate = 1'b0;
    endtask

    always @(posedge clk)
    begin : check_results
        result_t seen;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.color_write = m_axis_tuser[0];
            seen.color       = m_axis_tdata[2:0];
            seen.active_mode = m_axis_tdata[4:3];
            seen.shown_mode  = m_axis_tdata[8:5];
            results_seen++;
            if (led_expect_q.size() == 0)
            begin
                report_mismatch("unexpected beat, tdata", int'(m_axis_tdata), 0);
            end
            else
            begin
                want = led_expect_q.pop_front();
                if (seen.color_write !== want.color_write)
                    report_mismatch("color_write", int'(seen.color_write),
                                    int'(want.color_write));
                if (seen.color !== want.color)
                    report_mismatch("color", int'(seen.color), int'(want.color));
                if (seen.active_mode !== want.active_mode)
                    report_mismatch("active_mode", int'(seen.active_mode),
                                    int'(want.active_mode));
                if (seen.shown_mode !== want.shown_mode)
                    report_mismatch("shown_mode", int'(seen.shown_mode),
                                    int'(want.shown_mode));
            end
        end
    end

    initial
    begin : ready_side
        int stall_left;
        bit pressure_done;
        stall_left    = 0;
        pressure_done = 1'b0;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            // One long stall fills both pipeline stages and backs up the input.
            if (!pressure_done && results_seen >= 100)
            begin
                pressure_done = 1'b1;
                stall_left    = PRESSURE_CYCLES;
            end
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else if (steady_rate || $urandom_range(0, 4) != 0)
            begin
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= 1'b0;
                stall_left = gap_len();
            end
        end
    end

    initial
    begin : stimulus
        in_item_t  it;
        plan_row_t row;
        int        k;
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_data      <= 16'd0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'd0;
        s_axis_tuser  <= 1'b0;

        // After reset: steady green, then a sensor error blinking short.
        add_row(OP_TICK,    1'b0, 1'b0, ERR_NONE,   1'b1, 1'b1, COL_GREEN, MODE_STD,
                SHOWN_STD);
        add_row(OP_REFRESH, 1'b0, 1'b0, ERR_SEVEN,  1'b1, 1'b0, COL_RED,   MODE_STD,
                SHOWN_STD);
        add_row(OP_REFRESH, 1'b0, 1'b0, ERR_SENSOR, 1'b1, 1'b0, COL_RED,   MODE_STD,
                SHOWN_SENSOR);
        add_row(OP_TICK,    1'b0, 1'b0, ERR_NONE,   1'b1, 1'b0, COL_RED,   MODE_STD,
                SHOWN_SENSOR);
        add_row(OP_TICK,    1'b0, 1'b0, ERR_SEVEN,  1'b1, 1'b0, COL_RED,   MODE_STD,
                SHOWN_SENSOR);
        add_row(OP_TICK,    1'b0, 1'b0, ERR_NONE,   1'b1, 1'b1, COL_RED,   MODE_STD,
                SHOWN_SENSOR);
        add_row(OP_TICK,    1'b0, 1'b0, ERR_NONE,   1'b1, 1'b0, COL_RED,   MODE_STD,
                SHOWN_SENSOR);
        add_row(OP_TICK,    1'b0, 1'b0, ERR_NONE,   1'b1, 1'b1, COL_GREEN, MODE_STD,
                SHOWN_SENSOR);
        // Both buttons on a refresh show the active mode whatever the error.
        add_row(OP_REFRESH, 1'b1, 1'b1, ERR_INCOHERENT, 1'b1, 1'b0, COL_RED, MODE_STD,
                SHOWN_STD);
        add_row(OP_REFRESH, 1'b0, 1'b0, ERR_INCOHERENT, 1'b1, 1'b0, COL_RED, MODE_STD,
                SHOWN_INCOHERENT);
        for (k = 0; k < 5; k++)
            add_row(OP_TICK, 1'b0, 1'b0, ERR_NONE, 1'b0, 1'b0, COL_RED, MODE_STD,
                    SHOWN_STD);
        // Switching to a short blink past its matching points.
        add_row(OP_REFRESH, 1'b0, 1'b0, ERR_GPS, 1'b0, 1'b0, COL_RED, MODE_STD,
                SHOWN_STD);
        add_row(OP_TICK,    1'b0, 1'b0, ERR_CARD_FULL, 1'b0, 1'b0, COL_RED, MODE_STD,
                SHOWN_STD);
        add_row(OP_TICK,    1'b0, 1'b0, ERR_CLOCK, 1'b0, 1'b0, COL_RED, MODE_STD,
                SHOWN_STD);
        add_row(OP_REFRESH, 1'b0, 1'b0, ERR_NONE, 1'b0, 1'b0, COL_RED, MODE_STD,
                SHOWN_STD);
        add_row(OP_TICK,    1'b0, 1'b0, ERR_CARD_WRITE, 1'b0, 1'b0, COL_RED, MODE_STD,
                SHOWN_STD);
        // With a zero threshold every held tick switches, except green in maintenance mode.
        add_cfg(16'd0);
        add_row(OP_TICK, 1'b1, 1'b0, ERR_NONE, 1'b0, 1'b0, COL_RED, MODE_STD, SHOWN_STD);
        add_row(OP_TICK, 1'b1, 1'b0, ERR_NONE, 1'b0, 1'b0, COL_RED, MODE_STD, SHOWN_STD);
        add_row(OP_TICK, 1'b0, 1'b1, ERR_NONE, 1'b0, 1'b0, COL_RED, MODE_STD, SHOWN_STD);
        add_row(OP_TICK, 1'b1, 1'b1, ERR_NONE, 1'b0, 1'b0, COL_RED, MODE_STD, SHOWN_STD);
        add_row(OP_TICK, 1'b0, 1'b1, ERR_NONE, 1'b0, 1'b0, COL_RED, MODE_STD, SHOWN_STD);
        add_row(OP_TICK, 1'b1, 1'b0, ERR_NONE, 1'b0, 1'b0, COL_RED, MODE_STD, SHOWN_STD);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < plan_q.size(); k++)
        begin
            row = plan_q[k];
            if (row.is_cfg)
                write_press_ticks(row.cfg_val);
            else
                send_beat(row.item, row.typed, row.want);
        end

        write_press_ticks(16'd1);
        run_random(150);
        write_press_ticks(16'd2);
        run_random(150);

        // At the top threshold a held button never switches the mode.
        write_press_ticks(HOLD_TOP);
        steady_rate      = 1'b1;
        it               = '0;
        it.opcode        = OP_TICK;
        it.red_pressed   = 1'b1;
        for (k = 0; k < HOLD_RUN; k++)
            send_beat(it, 1'b0, '0);
        it.red_pressed   = 1'b0;
        it.green_pressed = 1'b1;
        for (k = 0; k < HOLD_RUN; k++)
            send_beat(it, 1'b0, '0);
        steady_rate = 1'b0;
        run_random(100);

        write_press_ticks(16'd3);
        run_random(150);
        write_press_ticks(16'($urandom_range(1, 8)));
        run_random(150);
        write_press_ticks(PRESS_TICKS_RESET);
        run_random(150);
        write_press_ticks(16'd0);
        run_random(150);

        s_axis_tvalid <= 1'b0;
        while (led_expect_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("tb_top: %0d beats in, %0d results checked, %0d threshold writes",
                 beats_sent, results_seen, cfg_writes);
        $display("tb_top: blink phases, mode toggles, long holds at the top threshold and a long stall seen");
        if (mismatch_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
